/* rtl/bdg4_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the Bayer offset table for the gray4 dither packer.
// No dependencies; every other file refers to this package by scoped names.
package bdg4_pkg;

  localparam int PANEL_SIZE    = 2048;
  localparam int COORD_W       = $clog2(PANEL_SIZE);
  localparam int COLOR_W       = 8;
  localparam int LUMA_W        = COLOR_W + 2;
  localparam int OFF_W         = 6;
  localparam int CALC_W        = 12;
  localparam int LEVEL_W       = 4;
  localparam int NIB_SEL_W     = 2;
  localparam int WORD_W        = 16;
  localparam int NIBBLES       = WORD_W / LEVEL_W;
  localparam int GRAY_SHIFT    = 6;
  localparam int FAST_SCALE_SH = 4;
  localparam int FAST_THRESH   = 512;
  localparam int LEVEL_MAX     = 15;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_MODE     = 1'b0,
    REG_INVERT_OUTPUT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               last_in_run;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              run_end;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   level;
    logic [NIB_SEL_W-1:0] nib_sel;
    logic                 last;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [OFF_W-1:0] bayer_offset(
    input logic [1:0] row,
    input logic [1:0] col
  );
    logic signed [OFF_W-1:0] off;
    unique case ({row, col})
      4'd0:  off = -6'sd30;
      4'd1:  off =  6'sd2;
      4'd2:  off = -6'sd22;
      4'd3:  off =  6'sd10;
      4'd4:  off =  6'sd18;
      4'd5:  off = -6'sd14;
      4'd6:  off =  6'sd26;
      4'd7:  off = -6'sd6;
      4'd8:  off = -6'sd18;
      4'd9:  off =  6'sd14;
      4'd10: off = -6'sd26;
      4'd11: off =  6'sd6;
      4'd12: off =  6'sd30;
      4'd13: off = -6'sd2;
      4'd14: off =  6'sd22;
      4'd15: off = -6'sd10;
    endcase
    return off;
  endfunction

endpackage

/* rtl/bayer_dither_gray4_packer.sv */
`timescale 1ns / 1ps
// Top level of the ordered-dither gray4 packer: config registers, front, queue, back.
// Depends on bdg4_pkg, bdg4_front, bdg4_fifo and bdg4_back.
//
//  port group | direction | handshake           | word
//  in_        | in        | in_valid / in_stall  | bdg4_pkg::in_item_t (one pixel)
//  out_       | out       | out_valid / out_stall| bdg4_pkg::out_item_t (packed word)
//  cfg_       | in        | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One pixel per cycle sustained while the queue is not full; the level is computed in the accept cycle and queued.
// A word is registered into the output once its closing pixel has passed through the queue.
// Synchronous active-low reset clears the queue, partial word, output valid and registers.
// Output stall backs up the queue; in_stall rises only when the queue is full.
module bayer_dither_gray4_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bdg4_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bdg4_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdg4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdg4_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic              fast_mode_r, fast_mode_nxt;
  logic              invert_r, invert_nxt;
  logic              push;
  logic              pop;
  bdg4_pkg::qent_t   push_data;
  bdg4_pkg::qent_t   head;
  bdg4_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    fast_mode_nxt = fast_mode_r;
    invert_nxt    = invert_r;
    if (cfg_valid && cfg_ready) begin
      unique case (bdg4_pkg::cfg_reg_t'(cfg_index))
        bdg4_pkg::REG_FAST_MODE:     fast_mode_nxt = cfg_wdata[0];
        bdg4_pkg::REG_INVERT_OUTPUT: invert_nxt    = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_mode_r <= 1'b0;
      invert_r    <= 1'b0;
    end else begin
      fast_mode_r <= fast_mode_nxt;
      invert_r    <= invert_nxt;
    end
  end

  bdg4_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fast_mode (fast_mode_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  bdg4_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  bdg4_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .invert_output (invert_r),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

/* rtl/bdg4_front.sv */
`timescale 1ns / 1ps
// Front end: takes a pixel, forms luma plus Bayer offset and classifies it into a level.
// Depends on bdg4_pkg; pushes one queue entry per accepted pixel.
module bdg4_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  bdg4_pkg::in_item_t in_data,
  input  logic               fast_mode,
  input  bdg4_pkg::q_stat_t  q_stat,
  output logic               push,
  output bdg4_pkg::qent_t    push_data
);

  logic [bdg4_pkg::LUMA_W-1:0]        luma;
  logic signed [bdg4_pkg::OFF_W-1:0]  off;
  logic signed [bdg4_pkg::CALC_W-1:0] luma_ext;
  logic signed [bdg4_pkg::CALC_W-1:0] off_ext;
  logic signed [bdg4_pkg::CALC_W-1:0] gray_v;
  logic signed [bdg4_pkg::CALC_W-1:0] fast_v;
  logic [bdg4_pkg::LEVEL_W-1:0]       gray_lvl;
  logic [bdg4_pkg::LEVEL_W-1:0]       fast_lvl;

  assign luma = {2'b00, in_data.red} + {1'b0, in_data.green, 1'b0} + {2'b00, in_data.blue};
  assign off  = bdg4_pkg::bayer_offset(in_data.pixel_row[1:0], in_data.pixel_col[1:0]);

  assign luma_ext = $signed({{(bdg4_pkg::CALC_W - bdg4_pkg::LUMA_W){1'b0}}, luma});
  assign off_ext  = {{(bdg4_pkg::CALC_W - bdg4_pkg::OFF_W){off[bdg4_pkg::OFF_W-1]}}, off};
  assign gray_v   = luma_ext + off_ext;
  assign fast_v   = luma_ext + (off_ext <<< bdg4_pkg::FAST_SCALE_SH);

  always_comb begin
    if (gray_v[bdg4_pkg::CALC_W-1]) begin
      gray_lvl = '0;
    end else if (|gray_v[bdg4_pkg::CALC_W-2:bdg4_pkg::GRAY_SHIFT+bdg4_pkg::LEVEL_W]) begin
      gray_lvl = bdg4_pkg::LEVEL_W'(bdg4_pkg::LEVEL_MAX);
    end else begin
      gray_lvl = gray_v[bdg4_pkg::GRAY_SHIFT+bdg4_pkg::LEVEL_W-1:bdg4_pkg::GRAY_SHIFT];
    end
  end

  assign fast_lvl = (fast_v < $signed(bdg4_pkg::CALC_W'(bdg4_pkg::FAST_THRESH)))
                    ? '0 : bdg4_pkg::LEVEL_W'(bdg4_pkg::LEVEL_MAX);

  assign in_stall          = q_stat.full;
  assign push              = in_valid && !q_stat.full;
  assign push_data.level   = fast_mode ? fast_lvl : gray_lvl;
  assign push_data.nib_sel = in_data.pixel_col[bdg4_pkg::NIB_SEL_W-1:0];
  assign push_data.last    = in_data.last_in_run;

endmodule

/* rtl/bdg4_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified pixels between the front end and the packer.
// Depends on bdg4_pkg for the entry type, depth and status struct.
module bdg4_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdg4_pkg::qent_t   push_data,
  input  logic              pop,
  output bdg4_pkg::qent_t   head,
  output bdg4_pkg::q_stat_t q_stat
);

  bdg4_pkg::qent_t              mem_r [bdg4_pkg::Q_DEPTH];
  logic [bdg4_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bdg4_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bdg4_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == bdg4_pkg::Q_CNT_W'(bdg4_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bdg4_pkg::Q_CNT_W'(bdg4_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r != '0)
    else $error("queue empty after push");

endmodule

/* rtl/bdg4_back.sv */
`timescale 1ns / 1ps
// Back end: merges levels into the partial word and emits finished words.
// Depends on bdg4_pkg; drains bdg4_fifo and owns the output register.
module bdg4_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                invert_output,
  input  bdg4_pkg::qent_t     head,
  input  bdg4_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bdg4_pkg::out_item_t out_data
);

  logic [bdg4_pkg::WORD_W-1:0] partial_r, partial_nxt;
  logic [bdg4_pkg::WORD_W-1:0] merged;
  logic                        emit;
  logic                        out_valid_r, out_valid_nxt;
  bdg4_pkg::out_item_t         out_data_r, out_data_nxt;

  always_comb begin
    merged = partial_r;
    for (int i = 0; i < bdg4_pkg::NIBBLES; i++) begin
      if (head.nib_sel == bdg4_pkg::NIB_SEL_W'(i)) begin
        merged[(bdg4_pkg::NIBBLES-1-i)*bdg4_pkg::LEVEL_W +: bdg4_pkg::LEVEL_W] = head.level;
      end
    end
  end

  assign emit = (head.nib_sel == bdg4_pkg::NIB_SEL_W'(bdg4_pkg::NIBBLES - 1)) || head.last;
  assign pop  = !q_stat.empty && (!emit || !out_valid_r || !out_stall);

  always_comb begin
    partial_nxt   = partial_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      if (emit) begin
        partial_nxt          = '0;
        out_valid_nxt        = 1'b1;
        out_data_nxt.packed_word = merged ^ {bdg4_pkg::WORD_W{invert_output}};
        out_data_nxt.run_end = head.last;
      end else begin
        partial_nxt = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(pop && emit))
    else $error("held word overwritten");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit |=> partial_r == '0)
    else $error("partial word not cleared after emission");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit |=> out_valid_r)
    else $error("emitted word not presented");

endmodule
